// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every edge out of reset
`define SSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition on one edge forces a result on the next edge
`define SSE_ASSERT_NEXT(lbl, cond, res, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (res)) \
    else $error(msg);

`endif

// ===== hdl/sse_pkg.sv =====
`default_nettype none

package sse_pkg;

  // default store depth and word width
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned VALUE_W  = 32;

  // controller to datapath
  typedef struct packed {
    logic load;     // accepted input word
    logic rd_pos;   // read the entry at the pass position
    logic rd_k;     // read the next scan entry
    logic first;    // take the pass position entry as current minimum
    logic scan;     // compare scan entry with current minimum
    logic swap;     // result taken: move the displaced entry
    logic finish;   // last result taken: clear the set
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_last;
    logic k_done;
    logic scan_last;
    logic pos_last;
  } status_t;

endpackage

`default_nettype wire

// ===== hdl/sse_if.sv =====
`default_nettype none

// input word channel
interface sse_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [sse_pkg::VALUE_W-1:0] value;
  logic                               last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

// result word channel
interface sse_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [sse_pkg::VALUE_W-1:0] sorted_value;
  logic                               final_res;
  logic                               dropped;

  modport source (output valid, output sorted_value, output final_res, output dropped,
                  input ready);
  modport sink   (input valid, input sorted_value, input final_res, input dropped,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/sse_ram.sv =====
`default_nettype none

module sse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hdl/sse_ctrl.sv =====
`default_nettype none

`include "assert_macros.svh"

module sse_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire sse_pkg::status_t status_i,
  output sse_pkg::cmd_t         cmd_o
);

  typedef enum logic [4:0] {
    LOAD  = 5'b00001,
    ISSUE = 5'b00010,
    CAPT  = 5'b00100,
    SCAN  = 5'b01000,
    EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // handshake outputs
  assign in_ready_o  = (state_q == LOAD);
  assign out_valid_o = (state_q == EMIT);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      LOAD: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (status_i.in_last) begin
            state_d = ISSUE;
          end
        end
      end
      ISSUE: begin
        cmd_o.rd_pos = 1'b1;
        state_d      = CAPT;
      end
      CAPT: begin
        cmd_o.first = 1'b1;
        cmd_o.rd_k  = 1'b1;
        state_d     = status_i.k_done ? EMIT : SCAN;
      end
      SCAN: begin
        cmd_o.scan = 1'b1;
        cmd_o.rd_k = 1'b1;
        if (status_i.scan_last) begin
          state_d = EMIT;
        end
      end
      EMIT: begin
        if (out_ready_i) begin
          cmd_o.swap = 1'b1;
          if (status_i.pos_last) begin
            cmd_o.finish = 1'b1;
            state_d      = LOAD;
          end else begin
            state_d = ISSUE;
          end
        end
      end
      default: begin
        state_d = LOAD;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // the two sides of the block never run at once
  `SSE_ASSERT(a_no_overlap, !(in_ready_o && out_valid_o), "load and emit overlap")
  // the final result returns the block to loading
  `SSE_ASSERT_NEXT(a_final_to_load, out_valid_o && out_ready_i && status_i.pos_last,
                   in_ready_o, "no return to load after final result")

endmodule

`default_nettype wire

// ===== hdl/sse_dp.sv =====
`default_nettype none

`include "assert_macros.svh"

module sse_dp #(
  parameter int unsigned CAPACITY = sse_pkg::CAPACITY
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire sse_pkg::cmd_t                      cmd_i,
  output sse_pkg::status_t                        status_o,
  input  wire logic signed [sse_pkg::VALUE_W-1:0] value_i,
  input  wire logic                               last_i,
  output logic signed [sse_pkg::VALUE_W-1:0]      sorted_value_o,
  output logic                                    final_res_o,
  output logic                                    dropped_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned VW = sse_pkg::VALUE_W;

  logic [CW-1:0]        fill_q;
  logic                 ovf_q;
  logic [AW-1:0]        pos_q;
  logic [CW-1:0]        k_q;
  logic [AW-1:0]        rd_idx_q;
  logic [AW-1:0]        best_idx_q;
  logic signed [VW-1:0] best_q;
  logic signed [VW-1:0] pos_val_q;

  logic                 full;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [VW-1:0]        ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [VW-1:0]        ram_rdata;
  logic signed [VW-1:0] rd_val;

  assign full   = (fill_q == CW'(CAPACITY));
  assign rd_val = $signed(ram_rdata);

  // store write: loading or moving the displaced entry
  assign ram_we    = (cmd_i.load && !full) || cmd_i.swap;
  assign ram_waddr = cmd_i.swap ? best_idx_q : fill_q[AW-1:0];
  assign ram_wdata = cmd_i.swap ? pos_val_q : value_i;
  assign ram_raddr = cmd_i.rd_pos ? pos_q : k_q[AW-1:0];

  sse_ram #(
    .WIDTH (VW),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // set bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ovf_q  <= 1'b0;
      pos_q  <= '0;
    end else if (cmd_i.finish) begin
      fill_q <= '0;
      ovf_q  <= 1'b0;
      pos_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          fill_q <= fill_q + CW'(1);
        end
      end
      if (cmd_i.swap) begin
        pos_q <= pos_q + AW'(1);
      end
    end
  end

  // scan index and address of the word in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q      <= '0;
      rd_idx_q <= '0;
    end else begin
      rd_idx_q <= ram_raddr;
      if (cmd_i.rd_pos) begin
        k_q <= CW'(pos_q) + CW'(1);
      end else if (cmd_i.rd_k) begin
        k_q <= k_q + CW'(1);
      end
    end
  end

  // running minimum, earliest wins on a tie
  always_ff @(posedge clk_i) begin
    if (cmd_i.first) begin
      best_q     <= rd_val;
      pos_val_q  <= rd_val;
      best_idx_q <= pos_q;
    end else if (cmd_i.scan && (rd_val < best_q)) begin
      best_q     <= rd_val;
      best_idx_q <= rd_idx_q;
    end
  end

  assign status_o.in_last   = last_i;
  assign status_o.k_done    = (k_q >= fill_q);
  assign status_o.scan_last = (CW'(rd_idx_q) + CW'(1) == fill_q);
  assign status_o.pos_last  = (CW'(pos_q) + CW'(1) == fill_q);

  assign sorted_value_o = best_q;
  assign final_res_o    = status_o.pos_last;
  assign dropped_o      = ovf_q;

  // the fill count never passes the store depth
  `SSE_ASSERT(a_fill_bound, fill_q <= CW'(CAPACITY), "fill count beyond capacity")
  // a word loaded while full leaves the fill at capacity and sets the drop flag
  `SSE_ASSERT_NEXT(a_full_holds, cmd_i.load && full && !cmd_i.finish,
                   fill_q == CW'(CAPACITY) && ovf_q, "dropped word changed the fill")

endmodule

`default_nettype wire

// ===== hdl/selection_sort_engine_core.sv =====
// channel | dir | payload                           | accepted when
// in_i    | in  | value, last                       | valid && ready
// out_o   | out | sorted_value, final_res, dropped  | valid && ready
//
// loading takes one cycle per word; a word arriving with the store full is dropped
// sorting of n words: each pass reads the entries from its position on through
//   the single read port of the element store (one entry per cycle), then emits
// each result leaves at the end of its pass; the next pass starts once it is taken
// a stalled result holds the block in its emit step; no word is taken meanwhile
// reset clears the controller and the set counters; the store needs no clearing
`default_nettype none

module selection_sort_engine_core #(
  parameter int unsigned CAPACITY = sse_pkg::CAPACITY
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sse_in_if.sink     in_i,
  sse_out_if.source  out_o
);

  sse_pkg::cmd_t    cmd;
  sse_pkg::status_t status;

  // sequencer
  sse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // store, counters and minimum search
  sse_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .value_i        (in_i.value),
    .last_i         (in_i.last),
    .sorted_value_o (out_o.sorted_value),
    .final_res_o    (out_o.final_res),
    .dropped_o      (out_o.dropped)
  );

endmodule

`default_nettype wire

// ===== sim/tb_selection_sort_engine_core.sv =====
`default_nettype none

module tb_selection_sort_engine_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = sse_pkg::CAPACITY;
  localparam int unsigned VW          = sse_pkg::VALUE_W;
  localparam int unsigned RANDOM_GOAL = 205;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned DRAIN_WAIT  = 400;

  typedef logic signed [VW-1:0] word_t;

  // one result word of the sorted set
  typedef struct packed {
    word_t value;
    logic  final_res;
    logic  dropped;
  } sorted_word_t;

  // one row of the directed table
  typedef struct {
    word_t        value;
    logic         last;
    bit           typed;
    sorted_word_t want;
  } stim_row_t;

  typedef enum int {VAL_WIDE, VAL_NARROW, VAL_EDGE} value_style_e;

  logic clk_i;
  logic rst_ni;

  sse_in_if  in_ch ();
  sse_out_if out_ch ();

  selection_sort_engine_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // model state: words of the open set and its drop flag
  word_t        open_set[$];
  bit           set_lost;
  sorted_word_t sorted_due[$];
  sorted_word_t fresh_sorted[$];
  stim_row_t    stim_table[$];

  int unsigned errors;
  int unsigned words_in;
  int unsigned sets_closed;
  int unsigned lossy_sets;
  int unsigned words_out;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned quiet_cycles;

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // take one accepted word into the model; a closing word yields the sorted set
  task automatic absorb_word(input word_t v, input logic l);
    word_t       arr[DEPTH];
    word_t       tmp;
    int unsigned n;
    int unsigned best;
    sorted_word_t res;
    begin
      fresh_sorted.delete();
      if (open_set.size() < DEPTH) open_set.push_back(v);
      else set_lost = 1'b1;
      if (l) begin
        n = open_set.size();
        for (int i = 0; i < n; i++) arr[i] = open_set[i];
        // pick the earliest smallest and swap it into place
        for (int p = 0; p + 1 < n; p++) begin
          best = p;
          for (int k = p + 1; k < n; k++) begin
            if (arr[k] < arr[best]) best = k;
          end
          tmp       = arr[best];
          arr[best] = arr[p];
          arr[p]    = tmp;
        end
        for (int i = 0; i < n; i++) begin
          res.value     = arr[i];
          res.final_res = (i + 1 == n);
          res.dropped   = set_lost;
          fresh_sorted.push_back(res);
        end
        sets_closed++;
        if (set_lost) lossy_sets++;
        open_set.delete();
        set_lost = 1'b0;
      end
    end
  endtask

  // offer one word, with random gaps, and wait for it to be taken
  task automatic send_word(input word_t v, input logic l, input bit typed,
                           input sorted_word_t want);
    begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_ch.valid <= 1'b0;
        @(negedge clk_i);
      end
      in_ch.valid <= 1'b1;
      in_ch.value <= v;
      in_ch.last  <= l;
      @(posedge clk_i);
      while (!in_ch.ready) @(posedge clk_i);
      words_in++;
      absorb_word(v, l);
      if (typed && l) sorted_due.push_back(want);
      else foreach (fresh_sorted[i]) sorted_due.push_back(fresh_sorted[i]);
      @(negedge clk_i);
    end
  endtask

  task automatic add_row(input word_t v, input logic l, input bit typed,
                         input word_t ev, input logic ef, input logic ed);
    stim_row_t r;
    begin
      r.value          = v;
      r.last           = l;
      r.typed          = typed;
      r.want.value     = ev;
      r.want.final_res = ef;
      r.want.dropped   = ed;
      stim_table.push_back(r);
    end
  endtask

  function automatic word_t pick_value(input value_style_e style);
    begin
      case (style)
        VAL_WIDE:   pick_value = $urandom;
        VAL_NARROW: pick_value = int'($urandom_range(8)) - 4;
        default: begin
          case ($urandom_range(5))
            0:       pick_value = {1'b1, {(VW-1){1'b0}}};
            1:       pick_value = {1'b0, {(VW-1){1'b1}}};
            2:       pick_value = '0;
            3:       pick_value = '1;
            4:       pick_value = 1;
            default: pick_value = $urandom;
          endcase
        end
      endcase
    end
  endfunction

  // receiver stalls, changed at the falling edge
  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // compare each taken result word with the oldest prediction
  always @(posedge clk_i) begin : sorted_check
    sorted_word_t want;
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready) begin
      words_out++;
      if (sorted_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected sorted word: expected none, actual %0d final %0b dropped %0b",
                 $time, out_ch.sorted_value, out_ch.final_res, out_ch.dropped);
      end else begin
        want = sorted_due.pop_front();
        if (out_ch.sorted_value !== want.value) begin
          errors++;
          $display("%0t: sorted_value mismatch: expected %0d, actual %0d",
                   $time, want.value, out_ch.sorted_value);
        end
        if (out_ch.final_res !== want.final_res) begin
          errors++;
          $display("%0t: final_res mismatch: expected %0b, actual %0b",
                   $time, want.final_res, out_ch.final_res);
        end
        if (out_ch.dropped !== want.dropped) begin
          errors++;
          $display("%0t: dropped mismatch: expected %0b, actual %0b",
                   $time, want.dropped, out_ch.dropped);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid === 1'b1 && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d sorted words still due",
                 $time, quiet_cycles, sorted_due.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    sorted_word_t none;
    int unsigned  set_len;
    int unsigned  pick;
    int unsigned  rnd_words;
    value_style_e style;

    none          = '0;
    errors        = 0;
    words_in      = 0;
    sets_closed   = 0;
    lossy_sets    = 0;
    words_out     = 0;
    quiet_cycles  = 0;
    rnd_words     = 0;
    set_lost      = 1'b0;
    send_idle_pct = 14;
    recv_idle_pct = 48;
    in_ch.valid   = 1'b0;
    in_ch.value   = '0;
    in_ch.last    = 1'b0;
    out_ch.ready  = 1'b0;
    rst_ni        = 1'b0;

    // single-word sets right after reset: extremes and zero
    add_row(32'sh8000_0000, 1'b1, 1'b1, 32'sh8000_0000, 1'b1, 1'b0);
    add_row(32'sh7fff_ffff, 1'b1, 1'b1, 32'sh7fff_ffff, 1'b1, 1'b0);
    add_row(32'sh0000_0000, 1'b1, 1'b1, 32'sh0000_0000, 1'b1, 1'b0);
    // mixed signs with a tie
    add_row(5, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(-3, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(32'sh7fff_ffff, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(-3, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(32'sh8000_0000, 1'b1, 1'b0, 0, 1'b0, 1'b0);
    // full store, then the closing word finds it full and is dropped
    for (int k = 0; k <= DEPTH; k++) begin
      add_row((k % 2) ? k * 1000003 : -k * 7, (k == DEPTH), 1'b0, 0, 1'b0, 1'b0);
    end

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (stim_table[i]) begin
      send_word(stim_table[i].value, stim_table[i].last, stim_table[i].typed,
                stim_table[i].want);
    end

    // random sets, mostly short, some full, a few overflowing
    while (rnd_words < RANDOM_GOAL) begin
      if (rnd_words < RANDOM_GOAL / 3) begin
        send_idle_pct = 14;
        recv_idle_pct = 48;
      end else if (rnd_words < 2 * RANDOM_GOAL / 3) begin
        send_idle_pct = 48;
        recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      pick = $urandom_range(99);
      if (pick < 60)      set_len = $urandom_range(5, 1);
      else if (pick < 85) set_len = $urandom_range(12, 6);
      else if (pick < 93) set_len = $urandom_range(DEPTH, 13);
      else                set_len = $urandom_range(DEPTH + 4, DEPTH + 1);
      style = value_style_e'($urandom_range(2));
      for (int k = 0; k < set_len; k++) begin
        send_word(pick_value(style), (k + 1 == set_len), 1'b0, none);
        rnd_words++;
      end
    end
    in_ch.valid <= 1'b0;

    // drain, then give the block time to show any stray word
    while (sorted_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("run covered %0d input words in %0d sets, %0d of them with dropped words",
             words_in, sets_closed, lossy_sets);
    $display("%0d sorted words taken under three stall mixes, %0d mismatches",
             words_out, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
